FILE: hw/rtl/acrw_pkg.sv
// Shared types, codes and constants for the AT command response watcher.
package acrw_pkg;

  localparam int unsigned PATTERN_BYTES_DEF = 8;
  localparam int unsigned TICK_MS_DEF       = 100;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam int unsigned HIST_DEPTH        = 11;
  localparam int unsigned CFG_IDX_W         = 4;
  localparam int unsigned CFG_DATA_W        = 10;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_BYTE  = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_RESEND  = 2'd1,
    EV_OK      = 2'd2,
    EV_TIMEOUT = 2'd3
  } event_t;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WINDOW = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LIMIT  = CFG_IDX_W'(1);

  localparam logic [9:0] CME_WINDOW_RST = 10'd350;
  localparam logic [9:0] CME_LIMIT_RST  = 10'd10;
  localparam logic [9:0] CNT_MAX        = 10'd1023;

  localparam logic [7:0] CHR_CR = 8'h0D;
  localparam logic [7:0] CHR_LF = 8'h0A;

  // last character in the low byte, matching the history layout (newest low)
  localparam logic [55:0] TXT_CONNECT   = "CONNECT";
  localparam logic [79:0] TXT_NOCARRIER = "NO CARRIER";
  localparam logic [87:0] TXT_CME       = "+CME ERROR:";

  typedef struct packed {
    req_t        req_type;
    logic [7:0]  rx_byte;
    logic [15:0] timeout_ms;
    logic [7:0]  retry_count;
    logic [63:0] expect_pattern;
    logic [3:0]  expect_len;
  } in_t;

  typedef struct packed {
    event_t cmd_event;
    logic   reset_request;
    logic   connect_seen;
    logic   carrier_lost;
    logic   online;
    logic   busy_res;
  } out_t;

  // classified request handed from front to back
  typedef struct packed {
    req_t        req_type;
    logic [7:0]  rx_byte;
    logic        tracked;
    logic [9:0]  ticks;
    logic [7:0]  retries;
    logic [63:0] pattern;
    logic [3:0]  len;
  } cmd_t;

  typedef struct packed {
    logic [9:0] window_ticks;
    logic [9:0] limit;
  } cfg_t;

endpackage

FILE: hw/rtl/at_command_response_watcher_core.sv
// Top level of the AT command response watcher: config registers, front, queue, back.
//
//   channel | ports                               | direction
//   --------+-------------------------------------+----------
//   request | in_valid, in_ready, in_data         | in
//   result  | out_valid, out_ready, out_data      | out
//   config  | cfg_valid, cfg_ready, cfg_index/data| in
//
// One request per cycle sustained when nothing stalls; a request's result passes
// through the front register, a queue entry and the result register.
// The timeout-to-tick conversion is one multiply in the front register stage.
// Synchronous active-low reset; no clearing pass, ready right after reset.
// A stalled result register backs up into the 2-entry queue, then the front.
module at_command_response_watcher_core import acrw_pkg::*; #(
  parameter int unsigned PATTERN_BYTES = PATTERN_BYTES_DEF,
  parameter int unsigned TICK_MS       = TICK_MS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic f_valid, f_ready, q_valid, q_ready;
  cmd_t f_data, q_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IDX_WINDOW: cfg_nxt.window_ticks = cfg_data[9:0];
        CFG_IDX_LIMIT:  cfg_nxt.limit        = cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_ticks <= CME_WINDOW_RST;
      cfg_r.limit        <= CME_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  acrw_front #(
    .PATTERN_BYTES(PATTERN_BYTES),
    .TICK_MS      (TICK_MS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cmd_valid(f_valid),
    .cmd_ready(f_ready),
    .cmd_data (f_data)
  );

  acrw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_data (f_data),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_data)
  );

  acrw_back #(
    .PATTERN_BYTES(PATTERN_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cmd_valid(q_valid),
    .cmd_ready(q_ready),
    .cmd_data (q_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

FILE: hw/rtl/acrw_front.sv
// Front stage: accepts requests, converts the timeout to ticks, clamps the length.
module acrw_front import acrw_pkg::*; #(
  parameter int unsigned PATTERN_BYTES = PATTERN_BYTES_DEF,
  parameter int unsigned TICK_MS       = TICK_MS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic cmd_valid,
  input  logic cmd_ready,
  output cmd_t cmd_data
);

  // reciprocal of TICK_MS, exact quotient for any 16-bit dividend
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / TICK_MS + 64'd1);

  logic        stg_v_r, stg_v_nxt;
  cmd_t        stg_r, stg_nxt;
  logic [48:0] prod;
  logic [16:0] quo;

  assign in_ready  = !stg_v_r || cmd_ready;
  assign cmd_valid = stg_v_r;
  assign cmd_data  = stg_r;

  assign prod = 49'(in_data.timeout_ms) * 49'(RECIP);
  assign quo  = prod[48:32];

  always_comb begin
    stg_nxt.req_type = in_data.req_type;
    stg_nxt.rx_byte  = in_data.rx_byte;
    stg_nxt.ticks    = (quo > 17'(CNT_MAX)) ? CNT_MAX : quo[9:0];
    stg_nxt.tracked  = (quo != 17'd0);
    stg_nxt.retries  = in_data.retry_count;
    stg_nxt.pattern  = in_data.expect_pattern;
    if (in_data.expect_len == 4'd0) begin
      stg_nxt.len = 4'd1;
    end else if (in_data.expect_len > 4'(PATTERN_BYTES)) begin
      stg_nxt.len = 4'(PATTERN_BYTES);
    end else begin
      stg_nxt.len = in_data.expect_len;
    end
  end

  always_comb begin
    stg_v_nxt = stg_v_r;
    if (in_valid && in_ready) begin
      stg_v_nxt = 1'b1;
    end else if (cmd_ready) begin
      stg_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_r <= stg_nxt;
    end
  end

endmodule

FILE: hw/rtl/acrw_queue.sv
// Short request queue between front and back.
module acrw_queue import acrw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t          mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != (AW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/acrw_back.sv
// Back stage: command tracking, received-byte matching, error window, result register.
module acrw_back import acrw_pkg::*; #(
  parameter int unsigned PATTERN_BYTES = PATTERN_BYTES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int unsigned HW = HIST_DEPTH * 8;

  logic        waiting_r, waiting_nxt;
  logic [9:0]  limit_r, limit_nxt;
  logic [9:0]  tick_r, tick_nxt;
  logic [7:0]  retries_r, retries_nxt;
  logic [63:0] pat_r, pat_nxt;
  logic [3:0]  len_r, len_nxt;
  logic        matched_r, matched_nxt;
  logic [HW-1:0] hist_r, hist_nxt;
  logic [3:0]  fill_r, fill_nxt;
  logic        line_err_r, line_err_nxt;
  logic [9:0]  err_cnt_r, err_cnt_nxt;
  logic [9:0]  win_r, win_nxt;
  logic        online_r, online_nxt;
  logic        out_v_r, out_v_nxt;
  out_t        out_r, res;

  logic [HW-1:0] hist_new;
  logic [3:0]    fill_inc;
  logic          hit_connect, hit_nocarrier, hit_cme, pat_hit;
  logic          pop, line_end;
  logic [7:0]    retries_dec;

  assign cmd_ready = !out_v_r || out_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  assign hist_new = {hist_r[HW-9:0], cmd_data.rx_byte};
  assign fill_inc = (fill_r == 4'(HIST_DEPTH)) ? fill_r : fill_r + 4'd1;

  assign hit_connect   = (fill_inc >= 4'd7)  && (hist_new[55:0] == TXT_CONNECT);
  assign hit_nocarrier = (fill_inc >= 4'd10) && (hist_new[79:0] == TXT_NOCARRIER);
  assign hit_cme       = (fill_inc >= 4'd11) && (hist_new[87:0] == TXT_CME);

  // one lane per pattern length; pattern byte 0 is the oldest of the suffix
  always_comb begin
    logic ok;
    pat_hit = 1'b0;
    for (int l = 1; l <= PATTERN_BYTES; l++) begin
      ok = (fill_inc >= 4'(l));
      for (int i = 0; i < l; i++) begin
        ok = ok && (hist_new[8*(l-1-i) +: 8] == pat_r[8*i +: 8]);
      end
      if (len_r == 4'(l)) begin
        pat_hit = ok;
      end
    end
  end

  assign line_end    = (cmd_data.rx_byte == CHR_CR) || (cmd_data.rx_byte == CHR_LF);
  assign retries_dec = (retries_r != 8'd0) ? retries_r - 8'd1 : retries_r;

  always_comb begin
    waiting_nxt  = waiting_r;
    limit_nxt    = limit_r;
    tick_nxt     = tick_r;
    retries_nxt  = retries_r;
    pat_nxt      = pat_r;
    len_nxt      = len_r;
    matched_nxt  = matched_r;
    hist_nxt     = hist_r;
    fill_nxt     = fill_r;
    line_err_nxt = line_err_r;
    err_cnt_nxt  = err_cnt_r;
    win_nxt      = win_r;
    online_nxt   = online_r;
    res          = '0;
    res.cmd_event = EV_NONE;

    if (pop) begin
      unique case (cmd_data.req_type)
        REQ_START: begin
          if (cmd_data.tracked) begin
            waiting_nxt  = 1'b1;
            limit_nxt    = cmd_data.ticks;
            tick_nxt     = '0;
            retries_nxt  = cmd_data.retries;
            pat_nxt      = cmd_data.pattern;
            len_nxt      = cmd_data.len;
            matched_nxt  = 1'b0;
            fill_nxt     = '0;
            line_err_nxt = 1'b0;
          end
        end
        REQ_BYTE: begin
          hist_nxt = hist_new;
          fill_nxt = fill_inc;
          if (waiting_r && pat_hit) begin
            matched_nxt = 1'b1;
          end
          if (hit_cme) begin
            line_err_nxt = 1'b1;
          end
          if (!waiting_r && line_end) begin
            if (line_err_r && (err_cnt_r != CNT_MAX)) begin
              err_cnt_nxt = err_cnt_r + 10'd1;
            end
            line_err_nxt = 1'b0;
            fill_nxt     = '0;
          end
          if (hit_connect) begin
            res.connect_seen = 1'b1;
            online_nxt       = 1'b1;
          end else if (hit_nocarrier) begin
            res.carrier_lost = 1'b1;
            online_nxt       = 1'b0;
            fill_nxt         = '0;
          end
        end
        REQ_TICK: begin
          if (waiting_r) begin
            if (tick_r >= limit_r) begin
              tick_nxt    = '0;
              retries_nxt = retries_dec;
            end else begin
              tick_nxt = tick_r + 10'd1;
            end
            if (matched_r) begin
              res.cmd_event = EV_OK;
              waiting_nxt   = 1'b0;
            end else if (tick_r >= limit_r) begin
              if (retries_dec == 8'd0) begin
                res.cmd_event = EV_TIMEOUT;
                waiting_nxt   = 1'b0;
              end else begin
                res.cmd_event = EV_RESEND;
              end
            end
          end
          if (err_cnt_r != 10'd0) begin
            if (win_r >= cfg.window_ticks) begin
              win_nxt           = '0;
              res.reset_request = (err_cnt_r >= cfg.limit);
              err_cnt_nxt       = '0;
            end else begin
              win_nxt = win_r + 10'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    res.online   = online_nxt;
    res.busy_res = waiting_nxt;
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (pop) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r  <= 1'b0;
      limit_r    <= '0;
      tick_r     <= '0;
      retries_r  <= '0;
      len_r      <= 4'd1;
      matched_r  <= 1'b0;
      fill_r     <= '0;
      line_err_r <= 1'b0;
      err_cnt_r  <= '0;
      win_r      <= '0;
      online_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      waiting_r  <= waiting_nxt;
      limit_r    <= limit_nxt;
      tick_r     <= tick_nxt;
      retries_r  <= retries_nxt;
      len_r      <= len_nxt;
      matched_r  <= matched_nxt;
      fill_r     <= fill_nxt;
      line_err_r <= line_err_nxt;
      err_cnt_r  <= err_cnt_nxt;
      win_r      <= win_nxt;
      online_r   <= online_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  // history and pattern bytes are only read below the fill count / while armed
  always_ff @(posedge clk) begin
    hist_r <= hist_nxt;
    pat_r  <= pat_nxt;
    if (pop) begin
      out_r <= res;
    end
  end

endmodule
